// File: hw/rtl/bucketed_hash_table_core_defines.svh
// Assertion macros for the bucketed hash table core.
// Used by bucketed_hash_table_core.sv; expects clk and rst_n in scope.
`ifndef BUCKETED_HASH_TABLE_CORE_DEFINES_SVH
`define BUCKETED_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bht_pkg.sv
// Shared types, codes and default sizes for the bucketed hash table core.
// No dependencies.
package bht_pkg;

    localparam int unsigned DEF_HOME_BUCKETS     = 256;
    localparam int unsigned DEF_SLOTS_PER_BUCKET = 3;
    localparam int unsigned DEF_OVERFLOW_BUCKETS = 64;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned COUNT_W = 10;

    typedef enum logic [1:0] {
        REQ_GET    = 2'd0,
        REQ_PUT    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STS_DONE     = 3'd0,
        STS_MISS     = 3'd1,
        STS_PRESENT  = 3'd2,
        STS_FULL     = 3'd3,
        STS_RESERVED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXAM
    } state_t;

endpackage

// File: hw/rtl/bucketed_hash_table_core.sv
// Bucketed key-value hash table: get / put / remove over home buckets plus overflow chains.
// A request is accepted in IDLE; the bucket is read in READ and examined in EXAM, with one more
// READ/EXAM pass per overflow bucket walked. One request at a time: the input stalls until the
// result is committed. The bucket memories have a synchronous read. A finished beat waits in
// the output register, and EXAM holds while that register is full and stalled.
// Reset: control clears at once, then a clearing pass over every bucket zeroes the key rows and
// chain links; the input side stalls during that pass.
// Depends on bht_pkg and bucketed_hash_table_core_defines.svh.
`include "bucketed_hash_table_core_defines.svh"

module bucketed_hash_table_core #(
    parameter int unsigned HOME_BUCKETS     = bht_pkg::DEF_HOME_BUCKETS,
    parameter int unsigned SLOTS_PER_BUCKET = bht_pkg::DEF_SLOTS_PER_BUCKET,
    parameter int unsigned OVERFLOW_BUCKETS = bht_pkg::DEF_OVERFLOW_BUCKETS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [bht_pkg::KEY_W-1:0]   key,
    input  logic [bht_pkg::KEY_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [bht_pkg::KEY_W-1:0]   value_out,
    output logic [bht_pkg::COUNT_W-1:0] entry_count
);

    localparam int unsigned TOTAL_BUCKETS = HOME_BUCKETS + OVERFLOW_BUCKETS;
    localparam int unsigned HOME_W   = $clog2(HOME_BUCKETS);
    localparam int unsigned BUCKET_W = $clog2(TOTAL_BUCKETS);
    localparam int unsigned LINK_W   = $clog2(OVERFLOW_BUCKETS + 1);
    localparam int unsigned LANE_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int unsigned KW       = bht_pkg::KEY_W;
    localparam int unsigned CW       = bht_pkg::COUNT_W;

    localparam logic [BUCKET_W-1:0] HOME_BASE  = BUCKET_W'(HOME_BUCKETS);
    localparam logic [BUCKET_W-1:0] LAST_BKT   = BUCKET_W'(TOTAL_BUCKETS - 1);
    localparam logic [LINK_W-1:0]   POOL_LIMIT = LINK_W'(OVERFLOW_BUCKETS);
    localparam logic [CW-1:0]       COUNT_MAX  = {CW{1'b1}};

    // Bucket memories: key lanes with chain link, and value lanes. One row per bucket.
    logic [SLOTS_PER_BUCKET-1:0][KW-1:0] key_mem  [TOTAL_BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0][KW-1:0] val_mem  [TOTAL_BUCKETS];
    logic [LINK_W-1:0]                   link_mem [TOTAL_BUCKETS];

    logic [SLOTS_PER_BUCKET-1:0][KW-1:0] key_row;
    logic [SLOTS_PER_BUCKET-1:0][KW-1:0] val_row;
    logic [LINK_W-1:0]                   link_row;

    bht_pkg::state_t state_reg, state_next;

    logic [BUCKET_W-1:0] clr_reg, clr_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [1:0]          req_reg;
    logic [KW-1:0]       key_reg;
    logic [KW-1:0]       val_reg;
    logic                emp_found_reg, emp_found_next;
    logic [BUCKET_W-1:0] emp_bucket_reg, emp_bucket_next;
    logic [LANE_W-1:0]   emp_lane_reg, emp_lane_next;
    logic [LINK_W-1:0]   pool_reg, pool_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [2:0]          status_reg;
    logic [KW-1:0]       vout_reg;

    logic in_accept;

    // Examine-stage decode.
    logic                        hit_any, emp_any;
    logic [LANE_W-1:0]           hit_lane, emp_lane;
    logic                        follow, finish, commit;
    bht_pkg::status_t            res_status;
    logic [KW-1:0]               res_vout;
    logic                        key_we, val_we, link_we;
    logic [BUCKET_W-1:0]         key_waddr, val_waddr, link_waddr;
    logic [SLOTS_PER_BUCKET-1:0] key_wmask;
    logic [KW-1:0]               key_wdata;
    logic [LANE_W-1:0]           val_wlane;
    logic [LINK_W-1:0]           link_wdata;
    logic                        cnt_inc, cnt_dec, do_alloc;

    assign in_accept = in_valid && !in_stall;
    assign commit    = (state_reg == bht_pkg::ST_EXAM) && finish
                       && (!out_valid_reg || !out_stall);

    // Compare every lane of the fetched row against the request key.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_lane = '0;
        emp_any  = 1'b0;
        emp_lane = '0;
        for (int l = SLOTS_PER_BUCKET - 1; l >= 0; l--)
        begin
            if (key_row[l] == key_reg)
            begin
                hit_any  = 1'b1;
                hit_lane = LANE_W'(l);
            end
            if (key_row[l] == '0)
            begin
                emp_any  = 1'b1;
                emp_lane = LANE_W'(l);
            end
        end
    end

    // Decide the outcome of the bucket just read: follow the chain or finish.
    always_comb
    begin
        follow     = 1'b0;
        finish     = 1'b0;
        res_status = bht_pkg::STS_MISS;
        res_vout   = '0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        do_alloc   = 1'b0;
        key_we     = 1'b0;
        key_waddr  = bucket_reg;
        key_wmask  = '0;
        key_wdata  = '0;
        val_we     = 1'b0;
        val_waddr  = bucket_reg;
        val_wlane  = '0;
        link_we    = 1'b0;
        link_waddr = bucket_reg;
        link_wdata = '0;
        emp_found_next  = emp_found_reg;
        emp_bucket_next = emp_bucket_reg;
        emp_lane_next   = emp_lane_reg;

        if (state_reg == bht_pkg::ST_CLEAR)
        begin
            key_we     = 1'b1;
            key_waddr  = clr_reg;
            key_wmask  = '1;
            link_we    = 1'b1;
            link_waddr = clr_reg;
        end
        else if (state_reg == bht_pkg::ST_IDLE)
        begin
            emp_found_next = 1'b0;
        end
        else if (state_reg == bht_pkg::ST_EXAM)
        begin
            if (key_reg == '0)
            begin
                finish     = 1'b1;
                res_status = bht_pkg::STS_RESERVED;
            end
            else if (req_reg == bht_pkg::REQ_GET || req_reg == bht_pkg::REQ_REMOVE)
            begin
                if (hit_any)
                begin
                    finish     = 1'b1;
                    res_status = bht_pkg::STS_DONE;
                    res_vout   = val_row[hit_lane];
                    if (req_reg == bht_pkg::REQ_REMOVE)
                    begin
                        key_we              = 1'b1;
                        key_wmask[hit_lane] = 1'b1;
                        cnt_dec             = 1'b1;
                    end
                end
                else if (link_row != '0)
                begin
                    follow = 1'b1;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            else if (req_reg == bht_pkg::REQ_PUT)
            begin
                if (hit_any)
                begin
                    finish     = 1'b1;
                    res_status = bht_pkg::STS_PRESENT;
                end
                else
                begin
                    // Remember the first empty slot met along the chain.
                    if (!emp_found_reg && emp_any)
                    begin
                        emp_found_next  = 1'b1;
                        emp_bucket_next = bucket_reg;
                        emp_lane_next   = emp_lane;
                    end
                    if (link_row != '0)
                    begin
                        follow = 1'b1;
                    end
                    else if (emp_found_next)
                    begin
                        finish                   = 1'b1;
                        res_status               = bht_pkg::STS_DONE;
                        key_we                   = 1'b1;
                        key_waddr                = emp_bucket_next;
                        key_wmask[emp_lane_next] = 1'b1;
                        key_wdata                = key_reg;
                        val_we                   = 1'b1;
                        val_waddr                = emp_bucket_next;
                        val_wlane                = emp_lane_next;
                        cnt_inc                  = 1'b1;
                    end
                    else if (pool_reg == POOL_LIMIT)
                    begin
                        finish     = 1'b1;
                        res_status = bht_pkg::STS_FULL;
                    end
                    else
                    begin
                        // Take the next pool bucket and link it behind the tail.
                        finish       = 1'b1;
                        res_status   = bht_pkg::STS_DONE;
                        do_alloc     = 1'b1;
                        key_we       = 1'b1;
                        key_waddr    = HOME_BASE + BUCKET_W'(pool_reg);
                        key_wmask[0] = 1'b1;
                        key_wdata    = key_reg;
                        val_we       = 1'b1;
                        val_waddr    = HOME_BASE + BUCKET_W'(pool_reg);
                        link_we      = 1'b1;
                        link_wdata   = pool_reg + LINK_W'(1);
                        cnt_inc      = 1'b1;
                    end
                end
            end
            else
            begin
                finish = 1'b1;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bht_pkg::ST_CLEAR: if (clr_reg == LAST_BKT) state_next = bht_pkg::ST_IDLE;
            bht_pkg::ST_IDLE:  if (in_valid) state_next = bht_pkg::ST_READ;
            bht_pkg::ST_READ:  state_next = bht_pkg::ST_EXAM;
            bht_pkg::ST_EXAM:
            begin
                if (follow)
                    state_next = bht_pkg::ST_READ;
                else if (commit)
                    state_next = bht_pkg::ST_IDLE;
            end
            default:           state_next = bht_pkg::ST_CLEAR;
        endcase
    end

    // Outputs and control register updates.
    always_comb
    begin
        in_stall       = (state_reg != bht_pkg::ST_IDLE);
        clr_next       = (state_reg == bht_pkg::ST_CLEAR) ? clr_reg + BUCKET_W'(1) : clr_reg;
        bucket_next    = bucket_reg;
        if (in_accept)
            bucket_next = BUCKET_W'(key[HOME_W-1:0]);
        else if (state_reg == bht_pkg::ST_EXAM && follow)
            bucket_next = HOME_BASE + BUCKET_W'(link_row) - BUCKET_W'(1);
        pool_next      = (commit && do_alloc) ? pool_reg + LINK_W'(1) : pool_reg;
        count_next     = count_reg;
        if (commit && cnt_inc && count_reg != COUNT_MAX)
            count_next = count_reg + CW'(1);
        else if (commit && cnt_dec && count_reg != '0)
            count_next = count_reg - CW'(1);
        out_valid_next = out_valid_reg && out_stall;
        if (commit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bht_pkg::ST_CLEAR;
            clr_reg       <= '0;
            emp_found_reg <= 1'b0;
            pool_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            emp_found_reg <= emp_found_next;
            pool_reg      <= pool_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold the request while it walks, the result while it waits.
    always_ff @(posedge clk)
    begin
        bucket_reg     <= bucket_next;
        emp_bucket_reg <= emp_bucket_next;
        emp_lane_reg   <= emp_lane_next;
        if (in_accept)
        begin
            req_reg <= req_type;
            key_reg <= key;
            val_reg <= value;
        end
        if (commit)
        begin
            status_reg <= res_status;
            vout_reg   <= res_vout;
        end
    end

    // Bucket memories: write lanes on commit or during the clearing pass, read one row a cycle.
    always_ff @(posedge clk)
    begin
        if (key_we && (commit || state_reg == bht_pkg::ST_CLEAR))
        begin
            for (int l = 0; l < SLOTS_PER_BUCKET; l++)
            begin
                if (key_wmask[l])
                    key_mem[key_waddr][l] <= key_wdata;
            end
        end
        if (val_we && commit)
            val_mem[val_waddr][val_wlane] <= val_reg;
        if (link_we && (commit || state_reg == bht_pkg::ST_CLEAR))
            link_mem[link_waddr] <= link_wdata;
        key_row  <= key_mem[bucket_reg];
        val_row  <= val_mem[bucket_reg];
        link_row <= link_mem[bucket_reg];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_count = count_reg;

    `BHT_ASSERT_NOW(a_pool_bound, 1'b1, pool_reg <= POOL_LIMIT, "pool count beyond pool size")
    `BHT_ASSERT_NEXT(a_count_hold, !commit, $stable(count_reg), "count moved without a commit")
    `BHT_ASSERT_NOW(a_clear_stall, state_reg == bht_pkg::ST_CLEAR, in_stall, "accepting while clearing")
    `BHT_ASSERT_NOW(a_out_source, $rose(out_valid_reg), $past(state_reg == bht_pkg::ST_EXAM), "result beat without examine")

endmodule

// File: bench/bucketed_hash_table_core_tb.sv
// Self-checking bench for bucketed_hash_table_core: get/put/remove beats checked against
// an in-bench table predictor. Depends on bht_pkg and the core RTL.
module bucketed_hash_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOMES   = bht_pkg::DEF_HOME_BUCKETS;
    localparam int unsigned SLOTS   = bht_pkg::DEF_SLOTS_PER_BUCKET;
    localparam int unsigned POOL    = bht_pkg::DEF_OVERFLOW_BUCKETS;
    localparam int unsigned BUCKETS = HOMES + POOL;
    localparam int unsigned NSLOT   = BUCKETS * SLOTS;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] k;
        logic [63:0] v;
    } req_beat_t;

    typedef struct packed {
        bht_pkg::status_t sts;
        logic [63:0]      val;
        logic [9:0]       cnt;
    } rsp_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = '0;
    logic [63:0] key = '0;
    logic [63:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [2:0] status;
    logic [63:0] value_out;
    logic [9:0] entry_count;

    bucketed_hash_table_core u_top (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Shadow table state
    logic [63:0] tbl_key [NSLOT];
    logic [63:0] tbl_val [NSLOT];
    int unsigned tbl_link [BUCKETS];
    int unsigned pool_taken;
    int unsigned live_count;

    req_beat_t pending_reqs[$];
    rsp_beat_t expected_rsps[$];
    logic [63:0] live_keys[$];
    int unsigned errors = 0;
    bit stim_done = 0;
    bit hold_off = 0;

    // Walk the chain of a key; return slot index or NSLOT when absent.
    function automatic int unsigned lookup_slot(logic [63:0] k);
        int unsigned b;
        b = 32'(k & 64'(HOMES - 1));
        for (int h = 0; h <= POOL && b < BUCKETS; h++)
        begin
            for (int j = 0; j < SLOTS; j++)
                if (tbl_key[b*SLOTS+j] == k) return b*SLOTS + j;
            b = (tbl_link[b] == 0 || tbl_link[b] > POOL) ? BUCKETS : HOMES + tbl_link[b] - 1;
        end
        return NSLOT;
    endfunction

    function automatic bht_pkg::status_t insert_key(logic [63:0] k, logic [63:0] v);
        int unsigned b, tail, free, nb;
        b = 32'(k & 64'(HOMES - 1));
        tail = b;
        free = NSLOT;
        for (int h = 0; h <= POOL && b < BUCKETS; h++)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                if (tbl_key[b*SLOTS+j] == k) return bht_pkg::STS_PRESENT;
                if (free == NSLOT && tbl_key[b*SLOTS+j] == 0) free = b*SLOTS + j;
            end
            tail = b;
            b = (tbl_link[b] == 0 || tbl_link[b] > POOL) ? BUCKETS : HOMES + tbl_link[b] - 1;
        end
        if (free == NSLOT)
        begin
            if (pool_taken >= POOL) return bht_pkg::STS_FULL;
            nb = HOMES + pool_taken;
            pool_taken++;
            tbl_link[nb] = 0;
            tbl_link[tail] = pool_taken;
            free = nb * SLOTS;
        end
        tbl_val[free] = v;
        tbl_key[free] = k;
        if (live_count < 1023) live_count++;
        return bht_pkg::STS_DONE;
    endfunction

    function automatic rsp_beat_t predict_table_op(req_beat_t r);
        rsp_beat_t o;
        int unsigned s;
        o.sts = bht_pkg::STS_MISS;
        o.val = '0;
        if (r.k == 0)
            o.sts = bht_pkg::STS_RESERVED;
        else if (r.op == bht_pkg::REQ_GET || r.op == bht_pkg::REQ_REMOVE)
        begin
            s = lookup_slot(r.k);
            if (s < NSLOT)
            begin
                o.sts = bht_pkg::STS_DONE;
                o.val = tbl_val[s];
                if (r.op == bht_pkg::REQ_REMOVE)
                begin
                    tbl_key[s] = '0;
                    if (live_count > 0) live_count--;
                end
            end
        end
        else if (r.op == bht_pkg::REQ_PUT)
            o.sts = insert_key(r.k, r.v);
        o.cnt = live_count[9:0];
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Keys with few distinct home buckets so chains grow and the pool drains.
    function automatic logic [63:0] crowded_key();
        logic [63:0] k;
        k = rand64();
        k[7:0] = 8'($urandom_range(0, 5));
        if (k == 0) k = 64'h100;
        return k;
    endfunction

    function automatic req_beat_t make_req(logic [1:0] op, logic [63:0] k, logic [63:0] v);
        req_beat_t r;
        r.op = op;
        r.k = k;
        r.v = v;
        return r;
    endfunction

    // Fill stimulus queue: directed beats first, then random ones.
    initial
    begin
        logic [63:0] k;
        int unsigned pick;
        for (int i = 0; i < NSLOT; i++) tbl_key[i] = '0;
        for (int i = 0; i < BUCKETS; i++) tbl_link[i] = 0;
        pool_taken = 0;
        live_count = 0;

        // Reserved key on every op, unknown op, miss, hit, duplicate, remove
        pending_reqs.push_back(make_req(bht_pkg::REQ_GET, 64'd0, '1));
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, 64'd0, '1));
        pending_reqs.push_back(make_req(bht_pkg::REQ_REMOVE, 64'd0, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_NONE, 64'h5, '1));
        pending_reqs.push_back(make_req(bht_pkg::REQ_GET, '1, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, '1, '1));
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, '1, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_GET, '1, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, 64'd1, 64'd0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, 64'h8000_0000_0000_0001,
                                        64'hAAAA_5555_AAAA_5555));
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, 64'h101, 64'h5555_AAAA_5555_AAAA));
        // fourth key in bucket 1 forces an overflow link
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, 64'h201, 64'h1234));
        pending_reqs.push_back(make_req(bht_pkg::REQ_GET, 64'h201, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_REMOVE, 64'h101, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_REMOVE, 64'h101, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_GET, 64'h201, '0));
        // reuse the freed home slot
        pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, 64'h301, 64'h77));
        pending_reqs.push_back(make_req(bht_pkg::REQ_REMOVE, '1, '0));
        pending_reqs.push_back(make_req(bht_pkg::REQ_NONE, 64'd0, '0));

        for (int i = 0; i < 1100; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                k = crowded_key();
                if ($urandom_range(0, 3) == 0) k = rand64();
                pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, k, rand64()));
                live_keys.push_back(k);
            end
            else if (pick < 90 && live_keys.size() > 0)
            begin
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                pending_reqs.push_back(make_req($urandom_range(0, 1) ? bht_pkg::REQ_GET
                                                                    : bht_pkg::REQ_REMOVE,
                                                k, rand64()));
            end
            else if (pick < 97)
                pending_reqs.push_back(make_req(2'($urandom_range(0, 3)),
                                                ($urandom_range(0, 1) ? rand64() : crowded_key()),
                                                rand64()));
            else
                pending_reqs.push_back(make_req(2'($urandom_range(0, 3)), 64'd0, rand64()));
        end
        // late puts make sure the pool runs out
        for (int i = 0; i < 60; i++)
            pending_reqs.push_back(make_req(bht_pkg::REQ_PUT, crowded_key(), rand64()));
        stim_done = 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: change at falling edge, hold payload while stalled.
    int unsigned send_gap = 0;
    bit beat_taken = 0;
    always @(posedge clk)
        beat_taken <= in_valid && !in_stall;

    always @(negedge clk)
    begin
        req_beat_t r;
        if (rst_n)
        begin
            if (in_valid && !beat_taken)
                ; // hold the offered beat
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && (!in_valid || beat_taken))
            begin
                r = pending_reqs.pop_front();
                req_type <= r.op;
                key <= r.k;
                value <= r.v;
                in_valid <= 1'b1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict at acceptance.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_rsps.push_back(predict_table_op(make_req(req_type, key, value)));
    end

    // Receiver stall: random waits, plus one long hold-off so the core backs up.
    int unsigned recv_wait = 0;
    int unsigned rsp_seen = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_seen == 40 && !hold_off)
            begin
                hold_off <= 1;
                recv_wait <= 400;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall && $urandom_range(0, 2) != 0)
            begin
                recv_wait <= $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: compare each accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        rsp_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat status=%0d", $time, status);
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (status !== e.sts)
                begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, e.sts, status);
                end
                if (value_out !== e.val)
                begin
                    errors++;
                    $display("%0t: value_out exp %h got %h", $time, e.val, value_out);
                end
                if (entry_count !== e.cnt)
                begin
                    errors++;
                    $display("%0t: entry_count exp %0d got %0d", $time, e.cnt, entry_count);
                end
            end
        end
    end

    // Watchdog and end of run.
    int unsigned quiet = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet >= STALL_LIMIT)
            begin
                $display("bucketed_hash_table_core_tb failed");
                $finish;
            end
            if (stim_done && pending_reqs.size() == 0 && !in_valid
                && expected_rsps.size() == 0)
            begin
                repeat (20) @(posedge clk);
                if (errors == 0 && !out_valid)
                    $display("bucketed_hash_table_core_tb passed");
                else
                    $display("bucketed_hash_table_core_tb failed");
                $finish;
            end
        end
    end
endmodule
